>>> hdl/vwdm_pkg.sv
// package for the voltage window debounce monitor
// widths, codes, register indexes and the configuration struct; no dependencies
package vwdm_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int COUNT_BITS    = 16;
  localparam int MODE_BITS     = 2;
  localparam int ZONE_BITS     = 3;
  localparam int OUT_DATA_BITS = ((MODE_BITS + ZONE_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_DEFAULT = 2'd0,
    MODE_ENTERED = 2'd1,
    MODE_EXITED  = 2'd2
  } mode_t;

  typedef enum logic [ZONE_BITS-1:0] {
    ZONE_NONE  = 3'd0,
    ZONE_ENTER = 3'd1,
    ZONE_EXIT  = 3'd2,
    ZONE_UPPER = 3'd3,
    ZONE_LOWER = 3'd4
  } zone_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENTER_LOW    = 3'd0,
    REG_ENTER_HIGH   = 3'd1,
    REG_EXIT_LOW     = 3'd2,
    REG_EXIT_HIGH    = 3'd3,
    REG_SETTLE_TICKS = 3'd4
  } reg_idx_t;

  localparam sample_t ENTER_LOW_RST    = '0;
  localparam sample_t ENTER_HIGH_RST   = '1;
  localparam sample_t EXIT_LOW_RST     = '0;
  localparam sample_t EXIT_HIGH_RST    = '1;
  localparam count_t  SETTLE_TICKS_RST = COUNT_BITS'(100);

  typedef struct packed {
    sample_t win_lo;
    sample_t win_hi;
    sample_t trip_lo;
    sample_t trip_hi;
    count_t  settle_ticks;
  } cfg_t;

endpackage

>>> hdl/voltage_window_debounce_monitor.sv
// Window comparator with hysteresis bands and a debounce counter for one
// converter channel. Every accepted sample gives exactly one result holding
// the qualified mode and the zone of that sample. A sample is registered on
// entry, classified and counted in one pass of compare and count logic, and
// its result lands in the output register once the output is free; a new
// sample is accepted every cycle while results are taken. Configuration
// writes are always ready and take effect on the next cycle; write them only
// while no sample is in flight.
// depends on vwdm_pkg, vwdm_cfg_regs, vwdm_zone_classify, vwdm_debounce
module voltage_window_debounce_monitor import vwdm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // [11:0] sample
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [1:0] mode, [4:2] zone
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t    cfg;
  logic    in_valid_r;
  logic    in_valid_nxt;
  sample_t sample_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  mode_t   out_mode_r;
  zone_t   out_zone_r;
  logic    advance;
  logic    step;
  zone_t   zone_cls;
  mode_t   mode_nxt;
  zone_t   zone_nxt;

  assign cfg_ready = 1'b1;

  vwdm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
    end
    if (advance) begin
      out_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sample_r <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (step) begin
      out_mode_r <= mode_nxt;
      out_zone_r <= zone_nxt;
    end
  end

  vwdm_zone_classify u_classify (
    .sample (sample_r),
    .cfg    (cfg),
    .zone   (zone_cls)
  );

  vwdm_debounce u_debounce (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .zone_in      (zone_cls),
    .settle_ticks (cfg.settle_ticks),
    .mode_nxt     (mode_nxt),
    .zone_nxt     (zone_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_BITS - MODE_BITS - ZONE_BITS)'(0), out_zone_r, out_mode_r};

endmodule

>>> hdl/vwdm_cfg_regs.sv
// configuration register file of the monitor
// depends on vwdm_pkg
module vwdm_cfg_regs import vwdm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [CFG_IDX_BITS-1:0]  wr_index,
  input  logic [CFG_DATA_BITS-1:0] wr_data,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_ENTER_LOW:    cfg_nxt.win_lo       = wr_data[SAMPLE_BITS-1:0];
        REG_ENTER_HIGH:   cfg_nxt.win_hi       = wr_data[SAMPLE_BITS-1:0];
        REG_EXIT_LOW:     cfg_nxt.trip_lo      = wr_data[SAMPLE_BITS-1:0];
        REG_EXIT_HIGH:    cfg_nxt.trip_hi      = wr_data[SAMPLE_BITS-1:0];
        REG_SETTLE_TICKS: cfg_nxt.settle_ticks = wr_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_lo       <= ENTER_LOW_RST;
      cfg_r.win_hi       <= ENTER_HIGH_RST;
      cfg_r.trip_lo      <= EXIT_LOW_RST;
      cfg_r.trip_hi      <= EXIT_HIGH_RST;
      cfg_r.settle_ticks <= SETTLE_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/vwdm_zone_classify.sv
// sample to zone classifier, first matching test wins
// depends on vwdm_pkg
module vwdm_zone_classify import vwdm_pkg::*; (
  input  sample_t sample,
  input  cfg_t    cfg,
  output zone_t   zone
);

  always_comb begin
    if (sample >= cfg.win_lo && sample <= cfg.win_hi) begin
      zone = ZONE_ENTER;
    end else if (sample >= cfg.trip_hi || sample <= cfg.trip_lo) begin
      zone = ZONE_EXIT;
    end else if (sample > cfg.win_hi) begin
      zone = ZONE_UPPER;
    end else begin
      zone = ZONE_LOWER;
    end
  end

endmodule

>>> hdl/vwdm_debounce.sv
// debounce counter and qualified mode state
// depends on vwdm_pkg
module vwdm_debounce import vwdm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   step,
  input  zone_t  zone_in,
  input  count_t settle_ticks,
  output mode_t  mode_nxt,
  output zone_t  zone_nxt
);

  mode_t  mode_r;
  zone_t  zone_r;
  zone_t  prev_zone_r;
  count_t count_r;
  zone_t  prev_zone_nxt;
  count_t count_nxt;
  count_t count_base;
  count_t count_inc;
  logic   qualify;
  mode_t  target;

  always_comb begin
    // late zone change check against the previously recorded zone
    count_base    = (zone_r != prev_zone_r) ? '0 : count_r;
    prev_zone_nxt = zone_r;
    count_inc     = (count_base == '1) ? count_base : count_base + 1'b1;
    qualify       = 1'b0;
    target        = MODE_ENTERED;
    mode_nxt      = mode_r;
    zone_nxt      = zone_in;
    count_nxt     = count_base;

    case (zone_in)
      ZONE_ENTER: begin
        qualify = (mode_r != MODE_ENTERED);
        target  = MODE_ENTERED;
      end
      ZONE_EXIT: begin
        qualify = (mode_r != MODE_EXITED);
        target  = MODE_EXITED;
      end
      default: begin
        count_nxt = '0;
      end
    endcase

    if (qualify) begin
      if (count_inc >= settle_ticks) begin
        mode_nxt  = target;
        count_nxt = '0;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_DEFAULT;
      zone_r      <= ZONE_NONE;
      prev_zone_r <= ZONE_NONE;
      count_r     <= '0;
    end else if (step) begin
      mode_r      <= mode_nxt;
      zone_r      <= zone_nxt;
      prev_zone_r <= prev_zone_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule
